// ===== rtl/mtp_pkg.sv =====
// Shared widths, types, constants and helper functions of the move-toward-point step.
`default_nettype none
package mtp_pkg;

	localparam int POS_W = 32;
	localparam int YAW_W = 16;
	localparam int D_W = 33;
	localparam int MAG_W = 32;
	localparam int SQ_W = 64;
	localparam int RAD_W = 66;
	localparam int LEN_W = 33;
	localparam int F_W = 31;
	localparam int PROD_W = 63;
	localparam int NUM_W = 64;
	localparam int Q_W = 32;
	localparam int REM_W = 35;
	localparam int SQRT_STAGES = 33;
	localparam int DIV_STEPS = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int ZW = 34;
	localparam int CW = 36;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int LANES = 3;

	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [ZW:0] YAW_MAX = 35'sd25736;
	localparam logic signed [ZW:0] ROUND_HALF = 35'sd65536;

	localparam logic [2:0] REG_DEST_X = 3'd0;
	localparam logic [2:0] REG_DEST_Y = 3'd1;
	localparam logic [2:0] REG_DEST_Z = 3'd2;
	localparam logic [2:0] REG_SPEED = 3'd3;
	localparam logic [2:0] REG_STOP = 3'd4;
	localparam logic [2:0] REG_FACE = 3'd5;
	localparam logic [2:0] REG_VERT = 3'd6;

	typedef struct packed {
		logic [POS_W-1:0] cx;
		logic [POS_W-1:0] cy;
		logic [POS_W-1:0] cz;
		logic [YAW_W-1:0] yaw;
	} cur_t;

	typedef struct packed {
		cur_t cur;
		logic arrive;
		logic [LANES-1:0][D_W-1:0] d;
	} fr_t;

	typedef struct packed {
		logic [POS_W-1:0] nx;
		logic [POS_W-1:0] ny;
		logic [POS_W-1:0] nz;
		logic [YAW_W-1:0] yaw;
		logic arrive;
		logic turn;
	} pos_t;

	function automatic logic [MAG_W-1:0] mag33(input logic signed [D_W-1:0] v);
		logic [D_W-1:0] n;
		n = v[D_W-1] ? D_W'(-v) : D_W'(v);
		return n[MAG_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] sat34(input logic signed [D_W:0] v);
		logic [POS_W-1:0] r;
		if (v > 34'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -34'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			10: r = 34'sd1048576;
			11: r = 34'sd524288;
			12: r = 34'sd262144;
			13: r = 34'sd131072;
			14: r = 34'sd65536;
			15: r = 34'sd32768;
			16: r = 34'sd16384;
			17: r = 34'sd8192;
			18: r = 34'sd4096;
			19: r = 34'sd2048;
			20: r = 34'sd1024;
			21: r = 34'sd512;
			22: r = 34'sd256;
			23: r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mtp_front.sv =====
// Offset, squared length and arrival test stages.
`default_nettype none
module mtp_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vld_in,
	input wire mtp_pkg::cur_t cur,
	input wire logic [mtp_pkg::POS_W-1:0] dest_x,
	input wire logic [mtp_pkg::POS_W-1:0] dest_y,
	input wire logic [mtp_pkg::POS_W-1:0] dest_z,
	input wire logic [mtp_pkg::F_W-1:0] speed,
	input wire logic [mtp_pkg::F_W-1:0] stop,
	input wire logic vert,
	output logic vld_out,
	output logic [mtp_pkg::RAD_W-1:0] sum,
	output mtp_pkg::fr_t side
);
	import mtp_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	logic [LANES-1:0][D_W-1:0] d_s1, d_s2, d_s3;
	logic [MAG_W-1:0] lim_s1;
	cur_t cur_s1, cur_s2, cur_s3;
	logic [LANES-1:0][SQ_W-1:0] sq_s2;
	logic [SQ_W-1:0] lsq_s2;
	logic [RAD_W-1:0] sum_s3;
	logic arrive_s3;
	logic [RAD_W-1:0] sum_c;
	logic [LANES-1:0][MAG_W-1:0] mag_c;

	always_comb begin
		sum_c = RAD_W'(sq_s2[0]) + RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2]);
		for (int k = 0; k < LANES; k++) begin
			mag_c[k] = mag33($signed(d_s1[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= D_W'($signed({dest_x[POS_W-1], dest_x}) - $signed({cur.cx[POS_W-1], cur.cx}));
			d_s1[1] <= vert ? D_W'($signed({dest_y[POS_W-1], dest_y})
				- $signed({cur.cy[POS_W-1], cur.cy})) : '0;
			d_s1[2] <= D_W'($signed({dest_z[POS_W-1], dest_z}) - $signed({cur.cz[POS_W-1], cur.cz}));
			lim_s1 <= MAG_W'(speed) + MAG_W'(stop);
			cur_s1 <= cur;
			for (int k = 0; k < LANES; k++) begin
				sq_s2[k] <= SQ_W'(mag_c[k]) * SQ_W'(mag_c[k]);
			end
			lsq_s2 <= SQ_W'(lim_s1) * SQ_W'(lim_s1);
			d_s2 <= d_s1;
			cur_s2 <= cur_s1;
			sum_s3 <= sum_c;
			arrive_s3 <= sum_c < RAD_W'(lsq_s2);
			d_s3 <= d_s2;
			cur_s3 <= cur_s2;
		end
	end

	assign vld_out = vld_s3;
	assign sum = sum_s3;
	assign side.cur = cur_s3;
	assign side.arrive = arrive_s3;
	assign side.d = d_s3;

endmodule
`default_nettype wire

// ===== rtl/mtp_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none
module mtp_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vld_in,
	input wire logic [mtp_pkg::RAD_W-1:0] rad,
	input wire mtp_pkg::fr_t side_in,
	output logic vld_out,
	output logic [mtp_pkg::LEN_W-1:0] len,
	output mtp_pkg::fr_t side_out
);
	import mtp_pkg::*;

	logic vld_s [0:SQRT_STAGES];
	logic [RAD_W-1:0] rad_s [0:SQRT_STAGES];
	logic [REM_W-1:0] rem_s [0:SQRT_STAGES];
	logic [LEN_W-1:0] root_s [0:SQRT_STAGES];
	fr_t side_s [0:SQRT_STAGES];

	assign vld_s[0] = vld_in;
	assign rad_s[0] = rad;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		logic [REM_W+1:0] cand;
		logic [REM_W+1:0] trial;
		logic ge;

		always_comb begin
			cand = {rem_s[i], rad_s[i][RAD_W-1 -: 2]};
			trial = (REM_W+2)'({root_s[i], 2'b01});
			ge = cand >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? REM_W'(cand - trial) : REM_W'(cand);
				root_s[i+1] <= {root_s[i][LEN_W-2:0], ge};
				rad_s[i+1] <= {rad_s[i][RAD_W-3:0], 2'b00};
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vld_out = vld_s[SQRT_STAGES];
	assign len = root_s[SQRT_STAGES];
	assign side_out = side_s[SQRT_STAGES];

endmodule
`default_nettype wire

// ===== rtl/mtp_scale.sv =====
// Three-lane pipelined scaling: offset * factor / length, rounded to nearest, one quotient bit per stage.
`default_nettype none
module mtp_scale (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vld_in,
	input wire logic [mtp_pkg::LEN_W-1:0] len,
	input wire logic [mtp_pkg::F_W-1:0] speed,
	input wire logic [mtp_pkg::F_W-1:0] stop,
	input wire mtp_pkg::fr_t side_in,
	output logic vld_out,
	output logic [mtp_pkg::LANES-1:0][mtp_pkg::D_W-1:0] m,
	output mtp_pkg::fr_t side_out
);
	import mtp_pkg::*;

	logic vld_s1, vld_s2, vld_out_q;
	logic [LANES-1:0][PROD_W-1:0] prod_s1;
	logic [LANES-1:0] neg_s1;
	logic [LEN_W-1:0] len_s1;
	fr_t side_s1;
	logic [F_W-1:0] f_c;
	logic [LANES-1:0][NUM_W-1:0] num_c;

	logic vld_s [0:DIV_STEPS];
	logic [LANES-1:0][LEN_W-1:0] rem_s [0:DIV_STEPS];
	logic [LANES-1:0][Q_W-1:0] w_s [0:DIV_STEPS];
	logic [LANES-1:0] neg_s [0:DIV_STEPS];
	logic [LEN_W-1:0] len_s [0:DIV_STEPS];
	fr_t side_s [0:DIV_STEPS];
	logic [LANES-1:0][D_W-1:0] m_q;
	fr_t side_q;

	assign f_c = side_in.arrive ? stop : speed;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			num_c[k] = NUM_W'(prod_s1[k]) + NUM_W'(len_s1 >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_out_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				prod_s1[k] <= PROD_W'(mag33($signed(side_in.d[k]))) * PROD_W'(f_c);
				neg_s1[k] <= side_in.d[k][D_W-1];
				rem_s[0][k] <= LEN_W'(num_c[k][NUM_W-1:Q_W]);
				w_s[0][k] <= num_c[k][Q_W-1:0];
			end
			len_s1 <= len;
			side_s1 <= side_in;
			neg_s[0] <= neg_s1;
			len_s[0] <= len_s1;
			side_s[0] <= side_s1;
		end
	end

	assign vld_s[0] = vld_s2;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [LANES-1:0][LEN_W:0] cand;
		logic [LANES-1:0] ge;

		always_comb begin
			for (int k = 0; k < LANES; k++) begin
				cand[k] = {rem_s[j][k], w_s[j][k][Q_W-1]};
				ge[k] = cand[k] >= (LEN_W+1)'(len_s[j]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < LANES; k++) begin
					rem_s[j+1][k] <= ge[k] ? LEN_W'(cand[k] - (LEN_W+1)'(len_s[j]))
						: LEN_W'(cand[k]);
					w_s[j+1][k] <= {w_s[j][k][Q_W-2:0], ge[k]};
				end
				neg_s[j+1] <= neg_s[j];
				len_s[j+1] <= len_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				if (len_s[DIV_STEPS] == '0)
					m_q[k] <= '0;
				else if (neg_s[DIV_STEPS][k])
					m_q[k] <= D_W'(-D_W'(w_s[DIV_STEPS][k]));
				else
					m_q[k] <= D_W'(w_s[DIV_STEPS][k]);
			end
			side_q <= side_s[DIV_STEPS];
		end
	end

	assign vld_out = vld_out_q;
	assign m = m_q;
	assign side_out = side_q;

endmodule
`default_nettype wire

// ===== rtl/mtp_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2 in Q3.13 radians, one rotation per stage.
`default_nettype none
module mtp_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vld_in,
	input wire logic [mtp_pkg::D_W-1:0] yin,
	input wire logic [mtp_pkg::D_W-1:0] xin,
	input wire mtp_pkg::pos_t side_in,
	output logic vld_out,
	output logic [mtp_pkg::YAW_W-1:0] angle,
	output mtp_pkg::pos_t side_out
);
	import mtp_pkg::*;

	logic vld_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] y_s [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_s [0:CORDIC_STEPS];
	pos_t side_s [0:CORDIC_STEPS];
	logic vld_q;
	logic [YAW_W-1:0] angle_q;
	pos_t side_q;
	logic signed [CW-1:0] xe, ye;
	logic signed [ZW:0] zr;

	assign xe = CW'($signed(xin));
	assign ye = CW'($signed(yin));
	assign zr = (ZW+1)'($signed(z_s[CORDIC_STEPS])) + ROUND_HALF >>> 17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			vld_q <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (xe < 0) begin
				z_s[0] <= (ye >= 0) ? PI_Q30 : -PI_Q30;
				x_s[0] <= -xe;
				y_s[0] <= -ye;
			end else begin
				z_s[0] <= '0;
				x_s[0] <= xe;
				y_s[0] <= ye;
			end
			side_s[0] <= side_in;
			if (zr > YAW_MAX)
				angle_q <= YAW_MAX[YAW_W-1:0];
			else if (zr < -YAW_MAX)
				angle_q <= YAW_W'(-YAW_MAX);
			else
				angle_q <= zr[YAW_W-1:0];
			side_q <= side_s[CORDIC_STEPS];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vld_out = vld_q;
	assign angle = angle_q;
	assign side_out = side_q;

endmodule
`default_nettype wire

// ===== rtl/move_toward_point_step.sv =====
// Top level of the move-toward-point step: register file, position update and pipeline control.
//
//  channel | direction | handshake              | payload
//  in      | request   | in_valid / in_stall    | cur_x, cur_y, cur_z, cur_yaw
//  out     | result    | out_valid / out_stall  | new_x, new_y, new_z, new_yaw, arrived
//  config  | APB       | psel, penable, pwrite  | paddr, pwdata, prdata
//
// One request enters per cycle while in_stall is low.
// The pipeline is made of the square root (33 stages), the divider (35 stages)
// and the CORDIC (26 stages) plus four stages of offset and position logic.
// Reset clears all valid bits and the configuration registers.
// A stalled result freezes the whole pipeline, so nothing is dropped or repeated.
`default_nettype none
module move_toward_point_step (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [mtp_pkg::ADDR_W-1:0] paddr,
	input wire logic [mtp_pkg::DATA_W-1:0] pwdata,
	output logic [mtp_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [mtp_pkg::POS_W-1:0] cur_x,
	input wire logic [mtp_pkg::POS_W-1:0] cur_y,
	input wire logic [mtp_pkg::POS_W-1:0] cur_z,
	input wire logic [mtp_pkg::YAW_W-1:0] cur_yaw,
	output logic out_valid,
	input wire logic out_stall,
	output logic [mtp_pkg::POS_W-1:0] new_x,
	output logic [mtp_pkg::POS_W-1:0] new_y,
	output logic [mtp_pkg::POS_W-1:0] new_z,
	output logic [mtp_pkg::YAW_W-1:0] new_yaw,
	output logic arrived
);
	import mtp_pkg::*;

	logic [POS_W-1:0] dest_x_q, dest_y_q, dest_z_q;
	logic [F_W-1:0] speed_q, stop_q;
	logic face_q, vert_q;
	logic [2:0] idx;
	logic en;
	cur_t cur;

	logic fr_vld, sq_vld, sc_vld, cd_vld;
	logic [RAD_W-1:0] fr_sum;
	fr_t fr_side, sq_side, sc_side;
	logic [LEN_W-1:0] sq_len;
	logic [LANES-1:0][D_W-1:0] sc_m;

	logic vld_s1;
	pos_t pos_s1;
	logic [D_W-1:0] mx_s1, mz_s1;
	pos_t pos_c;
	logic [LANES-1:0][D_W-1:0] mv_c;
	logic [LANES-1:0][POS_W-1:0] dest_c;
	logic [LANES-1:0][POS_W-1:0] np_c;
	logic stop_nz;

	logic [YAW_W-1:0] cd_angle;
	pos_t cd_side;

	assign idx = paddr[ADDR_W-1:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q <= '0;
			dest_y_q <= '0;
			dest_z_q <= '0;
			speed_q <= '0;
			stop_q <= '0;
			face_q <= 1'b0;
			vert_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_DEST_X: dest_x_q <= pwdata;
				REG_DEST_Y: dest_y_q <= pwdata;
				REG_DEST_Z: dest_z_q <= pwdata;
				REG_SPEED: speed_q <= pwdata[F_W-1:0];
				REG_STOP: stop_q <= pwdata[F_W-1:0];
				REG_FACE: face_q <= pwdata[0];
				REG_VERT: vert_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEST_X: prdata = dest_x_q;
			REG_DEST_Y: prdata = dest_y_q;
			REG_DEST_Z: prdata = dest_z_q;
			REG_SPEED: prdata = DATA_W'(speed_q);
			REG_STOP: prdata = DATA_W'(stop_q);
			REG_FACE: prdata = DATA_W'(face_q);
			REG_VERT: prdata = DATA_W'(vert_q);
			default: prdata = '0;
		endcase
	end

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	assign cur.cx = cur_x;
	assign cur.cy = cur_y;
	assign cur.cz = cur_z;
	assign cur.yaw = cur_yaw;

	mtp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(in_valid),
		.cur(cur),
		.dest_x(dest_x_q),
		.dest_y(dest_y_q),
		.dest_z(dest_z_q),
		.speed(speed_q),
		.stop(stop_q),
		.vert(vert_q),
		.vld_out(fr_vld),
		.sum(fr_sum),
		.side(fr_side)
	);

	mtp_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(fr_vld),
		.rad(fr_sum),
		.side_in(fr_side),
		.vld_out(sq_vld),
		.len(sq_len),
		.side_out(sq_side)
	);

	mtp_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(sq_vld),
		.len(sq_len),
		.speed(speed_q),
		.stop(stop_q),
		.side_in(sq_side),
		.vld_out(sc_vld),
		.m(sc_m),
		.side_out(sc_side)
	);

	assign stop_nz = stop_q != '0;
	assign dest_c[0] = dest_x_q;
	assign dest_c[1] = dest_y_q;
	assign dest_c[2] = dest_z_q;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			mv_c[k] = (sc_side.arrive && !stop_nz) ? sc_side.d[k] : sc_m[k];
		end
		np_c[0] = sc_side.cur.cx;
		np_c[1] = sc_side.cur.cy;
		np_c[2] = sc_side.cur.cz;
		for (int k = 0; k < LANES; k++) begin
			if (sc_side.arrive) begin
				if (k == 1 && !vert_q)
					np_c[k] = sc_side.cur.cy;
				else if (stop_nz)
					np_c[k] = sat34($signed({{2{dest_c[k][POS_W-1]}}, dest_c[k]})
						- $signed({sc_m[k][D_W-1], sc_m[k]}));
				else
					np_c[k] = dest_c[k];
			end else begin
				np_c[k] = sat34($signed({{2{np_c[k][POS_W-1]}}, np_c[k]})
					+ $signed({sc_m[k][D_W-1], sc_m[k]}));
			end
		end
		pos_c.nx = np_c[0];
		pos_c.ny = np_c[1];
		pos_c.nz = np_c[2];
		pos_c.yaw = sc_side.cur.yaw;
		pos_c.arrive = sc_side.arrive;
		pos_c.turn = face_q && (mv_c[0] != '0 || mv_c[2] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sc_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos_c;
			mx_s1 <= mv_c[0];
			mz_s1 <= mv_c[2];
		end
	end

	mtp_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(vld_s1),
		.yin(mx_s1),
		.xin(mz_s1),
		.side_in(pos_s1),
		.vld_out(cd_vld),
		.angle(cd_angle),
		.side_out(cd_side)
	);

	assign out_valid = cd_vld;
	assign new_x = cd_side.nx;
	assign new_y = cd_side.ny;
	assign new_z = cd_side.nz;
	assign new_yaw = cd_side.turn ? cd_angle : cd_side.yaw;
	assign arrived = cd_side.arrive;

endmodule
`default_nettype wire

// ===== sim/tb_move_toward_point_step.sv =====
// Self-checking testbench of the move-toward-point step: directed table, random requests, stalls.
`timescale 1ns / 1ps
module tb_move_toward_point_step;
	import mtp_pkg::*;

	typedef struct {
		logic [31:0] x, y, z;
		logic [15:0] yaw;
		logic arr;
	} step_t;

	typedef struct {
		logic [31:0] cx, cy, cz;
		logic [15:0] cyaw;
		bit known;
		logic [31:0] ex, ey, ez;
		logic [15:0] eyaw;
		logic earr;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [31:0] cur_x = '0, cur_y = '0, cur_z = '0;
	logic [15:0] cur_yaw = '0;
	logic out_valid, out_stall = 0;
	logic [31:0] new_x, new_y, new_z;
	logic [15:0] new_yaw;
	logic arrived;

	move_toward_point_step dut (.*);

	longint dst_x, dst_y, dst_z;
	longint unsigned spd, stp;
	bit face, vert;
	step_t pending_moves[$];
	int errors = 0, cycles = 0;
	int send_idle = 0, recv_idle = 0;
	row_t dir_rows[$];

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic longint unsigned isqrt128(logic [127:0] s);
		logic [127:0] r, t;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			t = r | (128'd1 << b);
			if (t * t <= s)
				r = t;
		end
		return r[63:0];
	endfunction

	function automatic longint shrink(longint d, longint unsigned f, longint unsigned len);
		longint unsigned m, q;
		if (len == 0)
			return 0;
		m = d < 0 ? -d : d;
		q = (m * f + len / 2) / len;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic longint sra(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [15:0] heading(longint y, longint x);
		longint a, nx;
		a = 0;
		if (x < 0) begin
			a = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 24; i++) begin
			if (y > 0) begin
				nx = x + sra(y, i);
				y = y - sra(x, i);
				a += longint'(atan_q30(i));
			end else begin
				nx = x - sra(y, i);
				y = y + sra(x, i);
				a -= longint'(atan_q30(i));
			end
			x = nx;
		end
		a = sra(a + 65536, 17);
		if (a > 25736) a = 25736;
		if (a < -25736) a = -25736;
		return a[15:0];
	endfunction

	function automatic step_t predict_move(logic [31:0] ix, iy, iz, logic [15:0] iyaw);
		step_t r;
		longint cx, cy, cz, dx, dy, dz, mx, my, mz, nx, ny, nz;
		longint unsigned lim, len;
		logic [127:0] sq;
		bit arr;
		cx = longint'($signed(ix));
		cy = longint'($signed(iy));
		cz = longint'($signed(iz));
		dx = dst_x - cx;
		dy = vert ? dst_y - cy : 0;
		dz = dst_z - cz;
		lim = spd + stp;
		sq = 128'($signed(dx) * $signed(dx)) + 128'($signed(dy) * $signed(dy))
			+ 128'($signed(dz) * $signed(dz));
		arr = sq < 128'(lim) * 128'(lim);
		len = isqrt128(sq);
		if (arr) begin
			if (stp > 0) begin
				mx = shrink(dx, stp, len);
				my = shrink(dy, stp, len);
				mz = shrink(dz, stp, len);
				nx = dst_x - mx;
				nz = dst_z - mz;
				ny = vert ? dst_y - my : cy;
			end else begin
				mx = dx; my = dy; mz = dz;
				nx = dst_x;
				nz = dst_z;
				ny = vert ? dst_y : cy;
			end
		end else begin
			mx = shrink(dx, spd, len);
			my = shrink(dy, spd, len);
			mz = shrink(dz, spd, len);
			nx = cx + mx;
			ny = cy + my;
			nz = cz + mz;
		end
		r.x = clamp32(nx);
		r.y = clamp32(ny);
		r.z = clamp32(nz);
		r.yaw = (face && (mx != 0 || mz != 0)) ? heading(mx, mz) : iyaw;
		r.arr = arr;
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= v;
		psel <= 1;
		pwrite <= 1;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_DEST_X: dst_x = longint'($signed(v));
			REG_DEST_Y: dst_y = longint'($signed(v));
			REG_DEST_Z: dst_z = longint'($signed(v));
			REG_SPEED: spd = v[30:0];
			REG_STOP: stp = v[30:0];
			REG_FACE: face = v[0];
			REG_VERT: vert = v[0];
			default: ;
		endcase
	endtask

	task automatic setup_move(logic [31:0] x, y, z, sp, st, logic f, vt);
		write_reg(REG_DEST_X, x);
		write_reg(REG_DEST_Y, y);
		write_reg(REG_DEST_Z, z);
		write_reg(REG_SPEED, sp);
		write_reg(REG_STOP, st);
		write_reg(REG_FACE, {31'd0, f});
		write_reg(REG_VERT, {31'd0, vt});
	endtask

	task automatic drain();
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (110) @(posedge clk);
	endtask

	task automatic send_request(logic [31:0] x, y, z, logic [15:0] yw);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cur_x <= x;
		cur_y <= y;
		cur_z <= z;
		cur_yaw <= yw;
		pending_moves.push_back(predict_move(x, y, z, yw));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rnd_pos();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF + $urandom_range(1);
			1: return $urandom_range(4000) - 2000;
			2: return ($urandom_range(200) - 100) << 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rnd_dist();
		case ($urandom_range(4))
			0: return 0;
			1: return 32'h7FFFFFFF;
			2: return $urandom_range(20) << 16;
			default: return $urandom & 32'h7FFFFFFF;
		endcase
	endfunction

	always @(posedge clk) begin
		out_stall <= (recv_idle != 0 && $urandom_range(99) < recv_idle);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_moves.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h %h %h %h %b",
						new_x, new_y, new_z, new_yaw, arrived);
			end else begin
				step_t e;
				e = pending_moves.pop_front();
				if (e.x !== new_x || e.y !== new_y || e.z !== new_z
						|| e.yaw !== new_yaw || e.arr !== arrived) begin
					errors++;
					if (errors <= 10)
						$display("exp %h %h %h %h %b got %h %h %h %h %b",
							e.x, e.y, e.z, e.yaw, e.arr,
							new_x, new_y, new_z, new_yaw, arrived);
				end
			end
		end
	end

	task automatic add_row(logic [31:0] x, y, z, logic [15:0] yw);
		row_t r;
		r.cx = x; r.cy = y; r.cz = z; r.cyaw = yw; r.known = 0;
		dir_rows.push_back(r);
	endtask

	initial begin
		row_t r;
		step_t e;
		dst_x = 0; dst_y = 0; dst_z = 0; spd = 0; stp = 0; face = 0; vert = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// After reset everything is zero: zero offset is not an arrival.
		r.cx = 0; r.cy = 0; r.cz = 0; r.cyaw = 16'h1234; r.known = 1;
		r.ex = 0; r.ey = 0; r.ez = 0; r.eyaw = 16'h1234; r.earr = 0;
		dir_rows.push_back(r);
		r.cx = 32'h80000000; r.cy = 32'h7FFFFFFF; r.cz = 32'h7FFFFFFF; r.cyaw = 16'h8000;
		r.ex = 32'h80000000; r.ey = 32'h7FFFFFFF; r.ez = 32'h7FFFFFFF; r.eyaw = 16'h8000;
		dir_rows.push_back(r);
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			send_request(r.cx, r.cy, r.cz, r.cyaw);
			e = pending_moves[$];
			if (e.x !== r.ex || e.y !== r.ey || e.z !== r.ez || e.yaw !== r.eyaw
					|| e.arr !== r.earr) begin
				errors++;
				if (errors <= 10)
					$display("exp %h %h %h %h %b got %h %h %h %h %b",
						r.ex, r.ey, r.ez, r.eyaw, r.earr,
						e.x, e.y, e.z, e.yaw, e.arr);
			end
		end
		in_valid <= 0;
		drain();

		setup_move(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h00030000, 0, 1, 1);
		dir_rows.delete();
		add_row(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h6488);
		add_row(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'h9B78);
		add_row(32'h7FFF0000, 32'h80000000, 32'h80000000, 0);
		add_row(32'h7FFFFFFF, 32'h80010000, 32'h80001000, 16'h7FFF);
		add_row(0, 0, 0, 16'hFFFF);
		foreach (dir_rows[i])
			send_request(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].cz, dir_rows[i].cyaw);
		in_valid <= 0;
		drain();

		setup_move(32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			1, 0);
		foreach (dir_rows[i])
			send_request(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].cz, dir_rows[i].cyaw);
		send_request(32'h00010000, 5, 32'hFFFF0000, 16'h0100);
		send_request(32'h00000000, 5, 32'h00000000, 16'h0100);
		in_valid <= 0;
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_idle = 0; end
				1: begin send_idle = 56; recv_idle = 0; end
				2: begin send_idle = 0; recv_idle = 56; end
				default: begin send_idle = 8; recv_idle = 8; end
			endcase
			setup_move(rnd_pos(), rnd_pos(), rnd_pos(), rnd_dist(), rnd_dist(),
				1'($urandom_range(1)), 1'($urandom_range(1)));
			for (int k = 0; k < 95; k++) begin
				if (k % 5 == 0)
					send_request(dst_x[31:0] + $urandom_range(8) - 4,
						dst_y[31:0] + $urandom_range(8) - 4,
						dst_z[31:0] + $urandom_range(8) - 4, 16'($urandom));
				else
					send_request(rnd_pos(), rnd_pos(), rnd_pos(), 16'($urandom));
				if (k == 50) begin
					in_valid <= 0;
					while (pending_moves.size() != 0)
						@(posedge clk);
				end
			end
			in_valid <= 0;
			drain();
		end
		recv_idle = 0;
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== move_toward_point_step.f =====
rtl/mtp_pkg.sv
rtl/mtp_front.sv
rtl/mtp_sqrt.sv
rtl/mtp_scale.sv
rtl/mtp_cordic.sv
rtl/move_toward_point_step.sv
sim/tb_move_toward_point_step.sv
